@@ design/sfd_pkg.sv @@
// Shared types and constants for the sensor frame deframer.
// No dependencies; imported by every module of the block.
package sfd_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned WORD_W    = 16;
    localparam int unsigned FRAME_LEN = 16;
    localparam int unsigned NUM_WORDS = FRAME_LEN / 2;
    localparam int unsigned IDX_W     = $clog2(FRAME_LEN);

    localparam logic [BYTE_W-1:0] SYNC_HI     = 8'hFF;
    localparam logic [BYTE_W-1:0] SYNC_LO     = 8'h00;
    localparam logic [BYTE_W-1:0] FIRST_LIMIT = 8'd16;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [WORD_W-1:0] t_word;
    typedef t_word [NUM_WORDS-1:0] t_words;

    // Per-byte control from the parser to the frame buffer and result stage
    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        logic             emit;
    } t_parse_ctl;

endpackage

@@ design/sfd_parser.sv @@
// Header hunt / frame check state machine, one byte per accepted request.
// Depends on sfd_pkg.
module sfd_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  sfd_pkg::t_byte      i_rx_byte,
    output sfd_pkg::t_parse_ctl o_ctl
);
    import sfd_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_WAIT_00 = 3'd1,
        PH_DATA    = 3'd2,
        PH_CHK_FF  = 3'd3,
        PH_CHK_00  = 3'd4
    } t_phase;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);

    t_phase           r_phase, n_phase, restart;
    logic [IDX_W-1:0] r_count, n_count;
    t_parse_ctl       ctl;

    always_comb begin
        restart = (i_rx_byte == SYNC_HI) ? PH_WAIT_00 : PH_HUNT;
        n_phase = r_phase;
        n_count = r_count;
        ctl     = '0;
        unique case (r_phase)
            PH_WAIT_00: begin
                if (i_rx_byte == SYNC_LO) begin
                    n_phase = PH_DATA;
                    n_count = '0;
                end else begin
                    n_phase = restart;
                end
            end
            PH_DATA: begin
                if (r_count == '0 && i_rx_byte >= FIRST_LIMIT) begin
                    n_phase = restart;
                    n_count = '0;
                end else begin
                    ctl.wr_en  = 1'b1;
                    ctl.wr_idx = r_count;
                    if (r_count == LAST_IDX) begin
                        n_count = '0;
                        n_phase = PH_CHK_FF;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                end
            end
            PH_CHK_FF: begin
                n_phase = (i_rx_byte == SYNC_HI) ? PH_CHK_00 : PH_HUNT;
            end
            PH_CHK_00: begin
                if (i_rx_byte != SYNC_LO) begin
                    n_phase = restart;
                end else begin
                    ctl.emit = 1'b1;
                    n_phase  = PH_DATA;
                    n_count  = '0;
                end
            end
            default: begin
                n_phase = restart;
                n_count = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_count <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    assign o_ctl = i_step ? ctl : '0;

endmodule

@@ design/sfd_frame_buf.sv @@
// Data byte store for the frame being collected; pairs bytes into big-endian words.
// Depends on sfd_pkg.
module sfd_frame_buf (
    input  logic                i_clk,
    input  sfd_pkg::t_parse_ctl i_ctl,
    input  sfd_pkg::t_byte      i_rx_byte,
    output sfd_pkg::t_words     o_words
);
    import sfd_pkg::*;

    t_byte r_data [FRAME_LEN];

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_data[i_ctl.wr_idx] <= i_rx_byte;
        end
    end

    for (genvar k = 0; k < NUM_WORDS; k++) begin : g_word
        assign o_words[k] = {r_data[2*k], r_data[2*k+1]};
    end

endmodule

@@ design/sensor_frame_deframer_top.sv @@
// Sensor frame deframer top: byte in, eight 16-bit motor words out per frame.
// A frame's words are loaded into the result register when its last header byte is accepted.
// Throughput: one byte per cycle while the result side keeps up; ready passes straight through.
// Input stalls whenever a result is held and the receiver is not ready.
// Reset (synchronous, active low) returns the parser to header hunt and empties the result.
// Depends on sfd_pkg, sfd_parser and sfd_frame_buf.
module sensor_frame_deframer_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_rx_valid,
    output logic           o_rx_ready,
    input  sfd_pkg::t_byte i_rx_byte,
    output logic           o_res_valid,
    input  logic           i_res_ready,
    output sfd_pkg::t_word o_motor1_current,
    output sfd_pkg::t_word o_motor1_position,
    output sfd_pkg::t_word o_motor2_current,
    output sfd_pkg::t_word o_motor2_position,
    output sfd_pkg::t_word o_motor3_current,
    output sfd_pkg::t_word o_motor3_position,
    output sfd_pkg::t_word o_motor4_current,
    output sfd_pkg::t_word o_motor4_position
);
    import sfd_pkg::*;

    logic       step;
    t_parse_ctl ctl;
    t_words     words;
    t_words     r_res;
    logic       r_res_valid;

    assign o_rx_ready = !r_res_valid || i_res_ready;
    assign step       = i_rx_valid && o_rx_ready;

    sfd_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_rx_byte (i_rx_byte),
        .o_ctl     (ctl)
    );

    sfd_frame_buf u_frame_buf (
        .i_clk     (i_clk),
        .i_ctl     (ctl),
        .i_rx_byte (i_rx_byte),
        .o_words   (words)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (ctl.emit) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.emit) begin
            r_res <= words;
        end
    end

    assign o_res_valid       = r_res_valid;
    assign o_motor1_current  = r_res[0];
    assign o_motor1_position = r_res[1];
    assign o_motor2_current  = r_res[2];
    assign o_motor2_position = r_res[3];
    assign o_motor3_current  = r_res[4];
    assign o_motor3_position = r_res[5];
    assign o_motor4_current  = r_res[6];
    assign o_motor4_position = r_res[7];

endmodule

@@ tb/sv/tb_sensor_frame_deframer_top.sv @@
// Testbench for sensor_frame_deframer_top: byte stream in, motor word frames out.
// Queue-fed driver, result monitor and frame tracker; depends on sfd_pkg and the RTL.
module tb_sensor_frame_deframer_top;
    import sfd_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned HOLD_CYCLES    = 400;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned MAX_REPORTS    = 10;

    typedef enum logic [2:0] {
        SEEK_HI,
        SEEK_LO,
        COLLECT,
        CONFIRM_HI,
        CONFIRM_LO
    } t_seek;

    logic   i_clk       = 1'b0;
    logic   i_rst_n     = 1'b0;
    logic   i_rx_valid  = 1'b0;
    t_byte  i_rx_byte   = '0;
    logic   i_res_ready = 1'b0;
    logic   o_rx_ready;
    logic   o_res_valid;
    t_word  o_motor1_current;
    t_word  o_motor1_position;
    t_word  o_motor2_current;
    t_word  o_motor2_position;
    t_word  o_motor3_current;
    t_word  o_motor3_position;
    t_word  o_motor4_current;
    t_word  o_motor4_position;

    t_byte        byte_q [$];
    t_words       motor_words_q [$];
    int unsigned  bytes_queued = 0;
    int unsigned  bytes_taken  = 0;
    int unsigned  fail_cnt     = 0;
    int unsigned  report_cnt   = 0;
    int unsigned  stuck_cycles = 0;
    int unsigned  send_gap     = 0;
    int unsigned  stall_left   = 0;
    int unsigned  hold_left    = 0;
    logic         hold_done    = 1'b0;
    logic         hold_req     = 1'b0;
    logic         idle_on      = 1'b1;

    t_seek            seek;
    logic [IDX_W-1:0] frame_idx;
    t_byte            frame_bytes [FRAME_LEN];

    string word_name [NUM_WORDS] = '{
        "motor1_current", "motor1_position", "motor2_current", "motor2_position",
        "motor3_current", "motor3_position", "motor4_current", "motor4_position"
    };

    sensor_frame_deframer_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_rx_valid        (i_rx_valid),
        .o_rx_ready        (o_rx_ready),
        .i_rx_byte         (i_rx_byte),
        .o_res_valid       (o_res_valid),
        .i_res_ready       (i_res_ready),
        .o_motor1_current  (o_motor1_current),
        .o_motor1_position (o_motor1_position),
        .o_motor2_current  (o_motor2_current),
        .o_motor2_position (o_motor2_position),
        .o_motor3_current  (o_motor3_current),
        .o_motor3_position (o_motor3_position),
        .o_motor4_current  (o_motor4_current),
        .o_motor4_position (o_motor4_position)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // failing byte may itself open a new header
    function automatic t_seek resync(input t_byte b);
        return (b == SYNC_HI) ? SEEK_LO : SEEK_HI;
    endfunction

    task automatic track_byte(input t_byte b);
        t_words w;
        int     k;
        case (seek)
            SEEK_LO: begin
                if (b == SYNC_LO) begin
                    seek      = COLLECT;
                    frame_idx = '0;
                end else begin
                    seek = resync(b);
                end
            end
            COLLECT: begin
                if (frame_idx == 0 && b >= FIRST_LIMIT) begin
                    seek = resync(b);
                end else begin
                    frame_bytes[frame_idx] = b;
                    if (frame_idx == FRAME_LEN - 1) begin
                        frame_idx = '0;
                        seek      = CONFIRM_HI;
                    end else begin
                        frame_idx = frame_idx + 1'b1;
                    end
                end
            end
            CONFIRM_HI: begin
                seek = (b == SYNC_HI) ? CONFIRM_LO : SEEK_HI;
            end
            CONFIRM_LO: begin
                if (b != SYNC_LO) begin
                    seek = resync(b);
                end else begin
                    for (k = 0; k < NUM_WORDS; k++)
                        w[k] = {frame_bytes[2*k], frame_bytes[2*k+1]};
                    motor_words_q.insert(motor_words_q.size(), w);
                    seek      = COLLECT;
                    frame_idx = '0;
                end
            end
            default: begin
                seek      = resync(b);
                frame_idx = '0;
            end
        endcase
    endtask

    // sender: one request per accepted byte
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_rx_valid <= 1'b0;
            i_rx_byte  <= '0;
            send_gap   <= 0;
            seek       = SEEK_HI;
            frame_idx  = '0;
        end else begin
            if (i_rx_valid && o_rx_ready) begin
                track_byte(i_rx_byte);
                bytes_taken++;
            end
            if (!i_rx_valid || o_rx_ready) begin
                if (send_gap != 0) begin
                    send_gap   <= send_gap - 1;
                    i_rx_valid <= 1'b0;
                end else if (idle_on && $urandom_range(0, 9) == 0) begin
                    send_gap   <= $urandom_range(0, 7);
                    i_rx_valid <= 1'b0;
                end else if (byte_q.size() != 0) begin
                    i_rx_valid <= 1'b1;
                    i_rx_byte  <= byte_q.pop_front();
                end else begin
                    i_rx_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_res_ready <= 1'b0;
            stall_left  <= 0;
            hold_left   <= 0;
            hold_done   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_res_ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_left   <= HOLD_CYCLES - 1;
            hold_done   <= 1'b1;
            i_res_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_res_ready <= 1'b0;
        end else if (idle_on && o_res_valid && $urandom_range(0, 2) == 0) begin
            stall_left  <= $urandom_range(0, 7);
            i_res_ready <= 1'b0;
        end else begin
            i_res_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : res_check
        t_words got;
        t_words want;
        int     k;
        if (i_rst_n && o_res_valid && i_res_ready) begin
            got = {o_motor4_position, o_motor4_current, o_motor3_position, o_motor3_current,
                   o_motor2_position, o_motor2_current, o_motor1_position, o_motor1_current};
            if (motor_words_q.size() == 0) begin
                fail_cnt++;
                if (report_cnt < MAX_REPORTS)
                    $display("unexpected result: expected none, got %h", got);
                report_cnt++;
            end else begin
                want = motor_words_q.pop_front();
                for (k = 0; k < NUM_WORDS; k++) begin
                    if (got[k] !== want[k]) begin
                        fail_cnt++;
                        if (report_cnt < MAX_REPORTS)
                            $display("%s: expected %h, got %h", word_name[k], want[k], got[k]);
                        report_cnt++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_rx_valid && o_rx_ready) || (o_res_valid && i_res_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles == WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    task automatic push_byte(input t_byte b);
        byte_q.insert(byte_q.size(), b);
        bytes_queued++;
    endtask

    task automatic push_sync();
        push_byte(SYNC_HI);
        push_byte(SYNC_LO);
    endtask

    task automatic push_payload();
        push_byte(t_byte'($urandom_range(0, FIRST_LIMIT - 1)));
        repeat (FRAME_LEN - 1) push_byte(t_byte'($urandom_range(0, 255)));
    endtask

    // mostly chained good frames, also doubled-header frames, the rest broken frames and line noise
    task automatic add_traffic(input int unsigned n);
        int unsigned start_cnt;
        int unsigned pick;
        start_cnt = bytes_queued;
        while (bytes_queued - start_cnt < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                push_sync();
                repeat ($urandom_range(1, 4)) begin
                    push_payload();
                    push_sync();
                end
            end else if (pick < 73) begin
                push_sync();
                push_byte(t_byte'($urandom_range(FIRST_LIMIT, 255)));
            end else if (pick < 81) begin
                push_sync();
                push_payload();
                push_byte(t_byte'($urandom_range(0, 254)));
            end else if (pick < 88) begin
                push_sync();
                push_payload();
                push_byte(SYNC_HI);
                push_byte(t_byte'($urandom_range(1, 255)));
            end else if (pick < 95) begin
                repeat ($urandom_range(1, 6)) push_byte(t_byte'($urandom_range(0, 255)));
            end else begin
                push_byte(SYNC_HI);
                push_sync();
                push_payload();
                push_sync();
            end
        end
    endtask

    task automatic settle();
        while (bytes_taken != bytes_queued || motor_words_q.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // doubled header start, extreme data, chained header, 0xFF as first data byte
        push_byte(SYNC_HI);
        push_sync();
        foreach (frame_bytes[k]) begin
            case (k)
                0:       push_byte(8'h0F);
                1, 3:    push_byte(8'hFF);
                2:       push_byte(8'h00);
                4:       push_byte(8'h80);
                5:       push_byte(8'h01);
                6:       push_byte(8'h7F);
                7:       push_byte(8'hFE);
                8, 9:    push_byte(8'h00);
                10, 11:  push_byte(8'hFF);
                12:      push_byte(8'h55);
                13:      push_byte(8'hAA);
                14:      push_byte(8'h12);
                default: push_byte(8'h34);
            endcase
        end
        push_sync();
        push_sync();
        settle();

        idle_on = 1'b1;
        add_traffic(280);
        settle();
        idle_on = 1'b0;
        add_traffic(80);
        settle();

        // long receiver hold while frames keep coming
        push_sync();
        repeat (16) begin
            push_payload();
            push_sync();
        end
        hold_req = 1'b1;
        settle();

        idle_on = 1'b1;
        add_traffic(80);
        settle();
        idle_on = 1'b0;
        add_traffic(100);
        settle();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        fail_cnt += motor_words_q.size();
        if (fail_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/sfd_pkg.sv
design/sfd_parser.sv
design/sfd_frame_buf.sv
design/sensor_frame_deframer_top.sv
tb/sv/tb_sensor_frame_deframer_top.sv
